@@ hw/rtl/ppdma_pkg.sv @@
package ppdma_pkg;

  localparam int unsigned PosW  = 18;
  localparam int unsigned BaseW = 32;
  localparam int unsigned SampW = 16;

  localparam logic [PosW-1:0] BUF0_OFFSET = 18'd65536;
  localparam logic [PosW-1:0] BUF1_OFFSET = 18'd73728;

  localparam logic [7:0] FLAG_BUF0 = 8'h20;
  localparam logic [7:0] FLAG_BUF1 = 8'h10;
  localparam logic [7:0] CTRL_KEEP = 8'hCF;

  localparam logic [1:0] MODE_PULL  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  localparam logic CFG_BUFFER_BASE    = 1'b0;
  localparam logic CFG_BUFFER_SAMPLES = 1'b1;

  typedef enum logic [1:0] {
    OP_PULL,
    OP_WRITE,
    OP_START,
    OP_STOP
  } op_e;

  typedef struct packed {
    logic [1:0]      mode;
    logic [PosW-1:0] request_length;
    logic [7:0]      control_value;
  } in_t;

  typedef struct packed {
    logic [BaseW-1:0] mem_address;
    logic [PosW-1:0]  grant_length;
    logic             more_data;
    logic [7:0]       status_byte;
    logic [PosW-1:0]  play_position;
    logic             active_buffer;
  } out_t;

  typedef struct packed {
    op_e             op;
    logic [PosW-1:0] request_length;
    logic [7:0]      control_value;
  } cmd_t;

  typedef struct packed {
    logic [BaseW-1:0] buffer_base;
    logic [SampW-1:0] buffer_samples;
  } cfg_t;

endpackage

@@ hw/rtl/ping_pong_sound_dma_pull.sv @@
// an accepted word is written into the queue, then popped by the back end into its result register
// throughput: one word per cycle while the output is not stalled; each pull is handled in the back end
// a two-word queue sits between front and back; stall rises only when it is full
// reset clears position, buffer, enable, status, queue and both config registers

module ping_pong_sound_dma_pull (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ppdma_pkg::in_t                    in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ppdma_pkg::out_t                   out_word_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [ppdma_pkg::BaseW-1:0]       cfg_data_i
);

  ppdma_pkg::cfg_t cfg_q, cfg_d;
  ppdma_pkg::cmd_t front_cmd, queue_cmd;
  logic            push, full, queue_valid, pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        ppdma_pkg::CFG_BUFFER_BASE:    cfg_d.buffer_base = cfg_data_i;
        ppdma_pkg::CFG_BUFFER_SAMPLES:
          cfg_d.buffer_samples = cfg_data_i[ppdma_pkg::SampW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ppdma_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  ppdma_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .valid_o (queue_valid),
    .pop_i   (pop),
    .cmd_o   (queue_cmd)
  );

  ppdma_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ hw/rtl/ppdma_front.sv @@
module ppdma_front (
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ppdma_pkg::in_t   in_word_i,
  input  logic             full_i,
  output logic             push_o,
  output ppdma_pkg::cmd_t  cmd_o
);

  ppdma_pkg::op_e op;

  always_comb begin
    unique case (in_word_i.mode)
      ppdma_pkg::MODE_PULL:  op = ppdma_pkg::OP_PULL;
      ppdma_pkg::MODE_WRITE: op = ppdma_pkg::OP_WRITE;
      ppdma_pkg::MODE_START: op = ppdma_pkg::OP_START;
      ppdma_pkg::MODE_STOP:  op = ppdma_pkg::OP_STOP;
      default:               op = ppdma_pkg::OP_STOP;
    endcase
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

  assign cmd_o.op             = op;
  assign cmd_o.request_length = in_word_i.request_length;
  // drain flag bits never come from the written byte
  assign cmd_o.control_value  = in_word_i.control_value & ppdma_pkg::CTRL_KEEP;

endmodule

@@ hw/rtl/ppdma_fifo.sv @@
module ppdma_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ppdma_pkg::cmd_t  cmd_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output ppdma_pkg::cmd_t  cmd_o
);

  ppdma_pkg::cmd_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign do_pop  = pop_i & valid_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

@@ hw/rtl/ppdma_back.sv @@
module ppdma_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ppdma_pkg::cfg_t  cfg_i,
  input  logic             cmd_valid_i,
  input  ppdma_pkg::cmd_t  cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ppdma_pkg::out_t  out_word_o
);

  logic [ppdma_pkg::PosW-1:0] pos_q, pos_d;
  logic                       cur_q, cur_d;
  logic                       on_q, on_d;
  logic [7:0]                 status_q, status_d;
  logic                       out_valid_q, out_valid_d;
  ppdma_pkg::out_t            out_q, out_d;

  logic [ppdma_pkg::PosW-1:0] buf_len, rem, grant, pos_eff, offs;
  logic [ppdma_pkg::PosW:0]   rel_addr;
  logic                       drained, stopped, new_cur;
  logic                       pop;

  assign pop       = cmd_valid_i & (~out_valid_q | ~out_stall_i);
  assign cmd_pop_o = pop;

  always_comb begin
    buf_len  = {cfg_i.buffer_samples, 2'b00};
    drained  = (pos_q >= buf_len);
    stopped  = drained & cur_q & ~on_q;
    new_cur  = (drained & ~stopped) ? ~cur_q : cur_q;
    pos_eff  = drained ? '0 : pos_q;
    rem      = drained ? buf_len : (buf_len - pos_q);
    grant    = (rem < cmd_i.request_length) ? rem : cmd_i.request_length;
    offs     = new_cur ? ppdma_pkg::BUF1_OFFSET : ppdma_pkg::BUF0_OFFSET;
    rel_addr = {1'b0, offs} + {1'b0, pos_eff};

    pos_d       = pos_q;
    cur_d       = cur_q;
    on_d        = on_q;
    status_d    = status_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;

    if (pop) begin
      out_valid_d = 1'b1;
      out_d.mem_address  = '0;
      out_d.grant_length = '0;
      out_d.more_data    = 1'b0;
      unique case (cmd_i.op)
        ppdma_pkg::OP_PULL: begin
          if (drained) begin
            status_d = status_q | (cur_q ? ppdma_pkg::FLAG_BUF1 : ppdma_pkg::FLAG_BUF0);
          end
          cur_d = new_cur;
          if (stopped) begin
            pos_d = '0;
          end else begin
            pos_d              = pos_eff + grant;
            out_d.mem_address  = {cfg_i.buffer_base[ppdma_pkg::BaseW-1:ppdma_pkg::PosW],
                                  {ppdma_pkg::PosW{1'b0}}}
                                 + {{(ppdma_pkg::BaseW-ppdma_pkg::PosW-1){1'b0}}, rel_addr};
            out_d.grant_length = grant;
            out_d.more_data    = 1'b1;
          end
        end
        ppdma_pkg::OP_WRITE: status_d = cmd_i.control_value;
        ppdma_pkg::OP_START: begin
          pos_d = '0;
          cur_d = 1'b0;
          on_d  = 1'b1;
        end
        ppdma_pkg::OP_STOP: on_d = 1'b0;
        default: on_d = on_q;
      endcase
      out_d.status_byte   = status_d;
      out_d.play_position = pos_d;
      out_d.active_buffer = cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      cur_q       <= 1'b0;
      on_q        <= 1'b0;
      status_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      cur_q       <= cur_d;
      on_q        <= on_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_no_data_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.more_data) |->
      (out_q.grant_length == '0 && out_q.mem_address == '0))
    else $error("stopped word carries data");
  a_start_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cmd_i.op == ppdma_pkg::OP_START) |=>
      (pos_q == '0 && !cur_q && on_q))
    else $error("start did not rewind");
  a_write_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cmd_i.op == ppdma_pkg::OP_WRITE) |=> (status_q[5:4] == 2'b00))
    else $error("control write left drain flags");
  a_state_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(pop) |-> (out_q.play_position == pos_q && out_q.active_buffer == cur_q))
    else $error("result state disagrees with registers");
`endif

endmodule

@@ sim/ping_pong_sound_dma_pull_check.sv @@
module ping_pong_sound_dma_pull_check
  import ppdma_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_t               in_word_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_t              out_word_i,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [BaseW-1:0]  cfg_data_i,
  output int                errors_o,
  output int                pending_o
);

  logic [BaseW-1:0] base_q;
  logic [SampW-1:0] samples_q;
  logic [PosW-1:0]  pos_q;
  logic             buf_q;
  logic             on_q;
  logic [7:0]       status_q;
  out_t             grant_q[$];
  out_t             want;
  int               words_seen;

  function automatic out_t advance_dma(in_t w);
    logic [31:0]     len;
    logic [31:0]     rem;
    logic [PosW-1:0] grant;
    logic            halted;
    out_t            r;
    r = '0;
    halted = 1'b0;
    case (op_e'(w.mode))
      OP_PULL: begin
        len = {14'd0, samples_q, 2'b00};
        if ({14'd0, pos_q} >= len) begin
          status_q = status_q | (buf_q ? FLAG_BUF1 : FLAG_BUF0);
          pos_q = '0;
          if (buf_q && !on_q) begin
            halted = 1'b1;
          end else begin
            buf_q = ~buf_q;
          end
          rem = len;
        end else begin
          rem = len - {14'd0, pos_q};
        end
        if (!halted) begin
          grant = (rem < {14'd0, w.request_length}) ? rem[PosW-1:0] : w.request_length;
          r.mem_address = {base_q[31:18], 18'd0} + (buf_q ? BUF1_OFFSET : BUF0_OFFSET)
                          + pos_q;
          pos_q = pos_q + grant;
          r.grant_length = grant;
          r.more_data = 1'b1;
        end
      end
      OP_WRITE: status_q = w.control_value & CTRL_KEEP;
      OP_START: begin
        pos_q = '0;
        buf_q = 1'b0;
        on_q = 1'b1;
      end
      default: on_q = 1'b0;
    endcase
    r.status_byte = status_q;
    r.play_position = pos_q;
    r.active_buffer = buf_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q = '0;
      samples_q = '0;
      pos_q = '0;
      buf_q = 1'b0;
      on_q = 1'b0;
      status_q = '0;
      grant_q.delete();
      errors_o = 0;
      words_seen = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_BUFFER_BASE) begin
          base_q = cfg_data_i;
        end else begin
          samples_q = cfg_data_i[SampW-1:0];
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (grant_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) begin
            $display("word %0d: unexpected result %h", words_seen, out_word_i);
          end
        end else begin
          want = grant_q.pop_front();
          if (out_word_i !== want) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("word %0d: expected addr %h len %h more %b status %h pos %h buf %b",
                       words_seen, want.mem_address, want.grant_length, want.more_data,
                       want.status_byte, want.play_position, want.active_buffer);
              $display("word %0d: got      addr %h len %h more %b status %h pos %h buf %b",
                       words_seen, out_word_i.mem_address, out_word_i.grant_length,
                       out_word_i.more_data, out_word_i.status_byte,
                       out_word_i.play_position, out_word_i.active_buffer);
            end
          end
        end
        words_seen++;
      end
      if (in_valid_i && !in_stall_i) begin
        grant_q.push_back(advance_dma(in_word_i));
      end
    end
    pending_o = grant_q.size();
  end

endmodule

@@ sim/ping_pong_sound_dma_pull_test.sv @@
module ping_pong_sound_dma_pull_test;
  import ppdma_pkg::*;

  localparam int CycleLimit = 400000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_t              in_word = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_word;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_BUFFER_BASE;
  logic [BaseW-1:0] cfg_data = '0;
  int               errors;
  int               pending;
  int               cycles = 0;
  int               send_gap = 0;
  int               recv_gap = 0;

  ping_pong_sound_dma_pull dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  ping_pong_sound_dma_pull_check check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_gap);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("ping_pong_sound_dma_pull: mismatch");
      $finish;
    end
  end

  function automatic in_t make_word(op_e op, logic [PosW-1:0] req, logic [7:0] ctrl);
    in_t w;
    w.mode = op;
    w.request_length = req;
    w.control_value = ctrl;
    return w;
  endfunction

  function automatic in_t random_word();
    int              pick;
    logic [PosW-1:0] req;
    op_e             op;
    pick = $urandom_range(99);
    if (pick < 70) begin
      op = OP_PULL;
    end else if (pick < 80) begin
      op = OP_WRITE;
    end else if (pick < 90) begin
      op = OP_START;
    end else begin
      op = OP_STOP;
    end
    case ($urandom_range(3))
      0: req = PosW'($urandom_range(0, 18'h3FFFF));
      3: req = PosW'($urandom_range(0, 2048));
      default: req = PosW'($urandom_range(0, 40));
    endcase
    return make_word(op, req, 8'($urandom_range(0, 255)));
  endfunction

  task automatic send(in_t w);
    while ($urandom_range(99) < send_gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // wait until every result word is back
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_buffers(logic [BaseW-1:0] base, logic [SampW-1:0] samples);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BUFFER_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= CFG_BUFFER_SAMPLES;
    cfg_data <= {16'd0, samples};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [SampW-1:0] samples;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero-length buffers right after reset, then stopped at buffer 1
    send(make_word(OP_PULL, 18'd5, 8'h00));
    send(make_word(OP_PULL, 18'd5, 8'h00));
    send(make_word(OP_START, 18'd0, 8'h00));
    send(make_word(OP_PULL, 18'h3FFFF, 8'h00));
    settle();

    // top base with ignored low bits
    load_buffers(32'hFFFF_FFFF, 16'd4);
    send(make_word(OP_START, 18'd0, 8'hFF));
    send(make_word(OP_PULL, 18'h3FFFF, 8'h00));
    send(make_word(OP_PULL, 18'd7, 8'h00));
    send(make_word(OP_PULL, 18'd0, 8'h00));
    send(make_word(OP_WRITE, 18'h3FFFF, 8'hFF));
    send(make_word(OP_PULL, 18'd100, 8'h00));
    send(make_word(OP_STOP, 18'd0, 8'h00));
    send(make_word(OP_PULL, 18'd1, 8'h00));
    send(make_word(OP_PULL, 18'd1, 8'h00));
    send(make_word(OP_WRITE, 18'd0, 8'h00));
    send(make_word(OP_START, 18'd0, 8'h00));
    send(make_word(OP_START, 18'd0, 8'h00));
    send(make_word(OP_PULL, 18'd16, 8'h00));
    send(make_word(OP_PULL, 18'd1, 8'h00));
    settle();

    // largest buffer, then shrink it under the current position
    load_buffers(32'h0000_0000, 16'hFFFF);
    send(make_word(OP_PULL, 18'h3FFFF, 8'h00));
    send(make_word(OP_PULL, 18'h3FFFF, 8'h00));
    send(make_word(OP_PULL, 18'd1000, 8'h00));
    settle();
    load_buffers(32'h0000_0000, 16'd2);
    send(make_word(OP_PULL, 18'd4, 8'h00));
    send(make_word(OP_PULL, 18'd4, 8'h00));
    settle();

    for (int seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin
          send_gap = 0;
          recv_gap = 0;
        end
        1: begin
          send_gap = 59;
          recv_gap = 0;
        end
        2: begin
          send_gap = 0;
          recv_gap = 59;
        end
        default: begin
          send_gap = 27;
          recv_gap = 27;
        end
      endcase
      if ($urandom_range(4) == 0) begin
        samples = SampW'($urandom_range(0, 16'hFFFF));
      end else begin
        samples = SampW'($urandom_range(0, 12));
      end
      load_buffers($urandom(), samples);
      for (int k = 0; k < 75; k++) begin
        if (k == 40 && (seg % 2) == 1) begin
          settle();
        end
        send(random_word());
      end
      settle();
    end

    if (errors == 0 && pending == 0) begin
      $display("ping_pong_sound_dma_pull: match");
    end else begin
      $display("ping_pong_sound_dma_pull: mismatch");
    end
    $finish;
  end

endmodule
